// File: hw/rtl/prqs_pkg.sv
package prqs_pkg;

	localparam int MAX_TASKS = 16;
	localparam int SLOT_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	// operation codes
	localparam logic [2:0] FN_CREATE  = 3'd0;
	localparam logic [2:0] FN_SCHED   = 3'd1;
	localparam logic [2:0] FN_EXIT    = 3'd2;
	localparam logic [2:0] FN_DESTROY = 3'd3;
	localparam logic [2:0] FN_TICK    = 3'd4;

	// status codes
	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_FULL     = 2'd1;
	localparam logic [1:0] STS_NOTFOUND = 2'd2;
	localparam logic [1:0] STS_NORUN    = 2'd3;

	localparam logic [31:0] INIT_ID       = 32'd1;
	localparam logic [7:0]  INIT_PRIO     = 8'd10;
	localparam logic [31:0] FIRST_ID      = 32'd2;
	localparam logic [7:0]  QUANTUM_RESET = 8'd10;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] task_id;
		logic [7:0]  priority_req;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [7:0]        prio;
		logic [31:0]       id;
	} entry_t;

endpackage

// File: hw/rtl/prqs_front.sv
module prqs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  prqs_pkg::cmd_t cmd_in,
	output logic           busy,
	output logic           cmd_valid,
	output prqs_pkg::cmd_t cmd_out,
	input  logic           cmd_pop
);

	prqs_pkg::cmd_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_out   = mem_q[rd_ptr_q];

	// hold incoming items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !cmd_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && cmd_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: hw/rtl/prqs_back.sv
module prqs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  prqs_pkg::cmd_t cmd_in,
	output logic           cmd_pop,
	input  logic [7:0]     quantum_q,
	output logic           done,
	output logic [1:0]     status,
	output logic [31:0]    new_task_id,
	output logic           running_valid,
	output logic [31:0]    running_id,
	output logic [4:0]     total_count,
	output logic [4:0]     active_count
);

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_ENQ, S_POP, S_DONE} state_t;

	state_t state_q;
	prqs_pkg::cmd_t cmd_q;

	logic [prqs_pkg::MAX_TASKS-1:0] used_q;
	logic [31:0] id_q [prqs_pkg::MAX_TASKS];
	prqs_pkg::entry_t rq_q [prqs_pkg::MAX_TASKS];
	logic [prqs_pkg::CNT_W-1:0] len_q;
	logic [prqs_pkg::CNT_W-1:0] total_q;
	prqs_pkg::entry_t cur_q;
	logic        cur_v_q;
	logic [31:0] nid_q;
	logic [7:0]  tick_q;
	logic [1:0]  sts_q;
	logic [31:0] newid_q;

	logic                       free_hit;
	logic [prqs_pkg::SLOT_W-1:0] free_slot;
	logic                       id_hit;
	logic [prqs_pkg::SLOT_W-1:0] id_slot;
	prqs_pkg::entry_t           ins_e;
	logic [prqs_pkg::CNT_W-1:0] ins_pos;
	logic                       ins_hit;
	prqs_pkg::entry_t           ins_arr [prqs_pkg::MAX_TASKS];
	logic [prqs_pkg::CNT_W-1:0] rem_pos;
	logic                       rem_hit;
	logic                       do_pop;
	prqs_pkg::entry_t           rem_arr [prqs_pkg::MAX_TASKS];
	logic [7:0]                 tick_inc;

	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign tick_inc = tick_q + 8'd1;
	assign do_pop   = (state_q == S_POP);

	// find lowest free slot and lowest slot holding the id
	always_comb begin
		free_hit  = 1'b0;
		free_slot = '0;
		id_hit    = 1'b0;
		id_slot   = '0;
		for (int s = 0; s < prqs_pkg::MAX_TASKS; s++) begin
			if (!free_hit && !used_q[s]) begin
				free_hit  = 1'b1;
				free_slot = prqs_pkg::SLOT_W'(s);
			end
			if (!id_hit && used_q[s] && id_q[s] == cmd_q.task_id) begin
				id_hit  = 1'b1;
				id_slot = prqs_pkg::SLOT_W'(s);
			end
		end
	end

	// ordered insert: behind all entries of equal or higher priority
	always_comb begin
		if (state_q == S_ENQ) ins_e = cur_q;
		else ins_e = '{slot: free_slot, prio: cmd_q.priority_req, id: nid_q};
		ins_hit = 1'b0;
		ins_pos = len_q;
		for (int k = 0; k < prqs_pkg::MAX_TASKS; k++) begin
			if (!ins_hit && prqs_pkg::CNT_W'(k) < len_q && rq_q[k].prio < ins_e.prio) begin
				ins_hit = 1'b1;
				ins_pos = prqs_pkg::CNT_W'(k);
			end
		end
		ins_arr[0] = (ins_pos == '0) ? ins_e : rq_q[0];
		for (int k = 1; k < prqs_pkg::MAX_TASKS; k++) begin
			if (prqs_pkg::CNT_W'(k) < ins_pos) ins_arr[k] = rq_q[k];
			else if (prqs_pkg::CNT_W'(k) == ins_pos) ins_arr[k] = ins_e;
			else ins_arr[k] = rq_q[k-1];
		end
	end

	// removal: head on pop, else the entry of the destroyed slot
	always_comb begin
		rem_hit = do_pop && (len_q != '0);
		rem_pos = '0;
		if (state_q == S_EXEC && cmd_q.func == prqs_pkg::FN_DESTROY && id_hit) begin
			for (int k = 0; k < prqs_pkg::MAX_TASKS; k++) begin
				if (!rem_hit && prqs_pkg::CNT_W'(k) < len_q && rq_q[k].slot == id_slot) begin
					rem_hit = 1'b1;
					rem_pos = prqs_pkg::CNT_W'(k);
				end
			end
		end
		for (int k = 0; k < prqs_pkg::MAX_TASKS - 1; k++) begin
			if (prqs_pkg::CNT_W'(k) < rem_pos) rem_arr[k] = rq_q[k];
			else rem_arr[k] = rq_q[k+1];
		end
		rem_arr[prqs_pkg::MAX_TASKS-1] = rq_q[prqs_pkg::MAX_TASKS-1];
	end

	// queue and slot payload
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && cmd_q.func == prqs_pkg::FN_CREATE && free_hit) begin
			rq_q <= ins_arr;
		end else if (state_q == S_ENQ && cur_v_q && len_q < prqs_pkg::CNT_W'(prqs_pkg::MAX_TASKS)) begin
			rq_q <= ins_arr;
		end else if (rem_hit) begin
			rq_q <= rem_arr;
		end
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
			used_q  <= prqs_pkg::MAX_TASKS'(1);
			for (int s = 0; s < prqs_pkg::MAX_TASKS; s++) id_q[s] <= '0;
			id_q[0] <= prqs_pkg::INIT_ID;
			len_q   <= '0;
			total_q <= prqs_pkg::CNT_W'(1);
			cur_q   <= '{slot: '0, prio: prqs_pkg::INIT_PRIO, id: prqs_pkg::INIT_ID};
			cur_v_q <= 1'b1;
			nid_q   <= prqs_pkg::FIRST_ID;
			tick_q  <= '0;
			sts_q   <= prqs_pkg::STS_OK;
			newid_q <= '0;
			done    <= 1'b0;
			status  <= prqs_pkg::STS_OK;
			new_task_id   <= '0;
			running_valid <= 1'b0;
			running_id    <= '0;
			total_count   <= '0;
			active_count  <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd_in;
						sts_q   <= prqs_pkg::STS_OK;
						newid_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (cmd_q.func)
						prqs_pkg::FN_CREATE: begin
							if (!free_hit) begin
								sts_q <= prqs_pkg::STS_FULL;
							end else begin
								used_q[free_slot] <= 1'b1;
								id_q[free_slot]   <= nid_q;
								newid_q <= nid_q;
								nid_q   <= nid_q + 32'd1;
								total_q <= total_q + 1'b1;
								len_q   <= len_q + 1'b1;
							end
						end
						prqs_pkg::FN_SCHED: state_q <= S_ENQ;
						prqs_pkg::FN_EXIT: begin
							if (!cur_v_q) begin
								sts_q <= prqs_pkg::STS_NORUN;
							end else begin
								used_q[cur_q.slot] <= 1'b0;
								total_q <= total_q - 1'b1;
								cur_v_q <= 1'b0;
								state_q <= S_POP;
							end
						end
						prqs_pkg::FN_DESTROY: begin
							if (!id_hit) begin
								sts_q <= prqs_pkg::STS_NOTFOUND;
							end else begin
								used_q[id_slot] <= 1'b0;
								total_q <= total_q - 1'b1;
								if (cur_v_q && cur_q.slot == id_slot) begin
									cur_v_q <= 1'b0;
									state_q <= S_POP;
								end else if (rem_hit) begin
									len_q <= len_q - 1'b1;
								end
							end
						end
						prqs_pkg::FN_TICK: begin
							if (tick_inc >= quantum_q) begin
								tick_q  <= '0;
								state_q <= S_ENQ;
							end else begin
								tick_q <= tick_inc;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_ENQ: begin
					// put the running task back behind its equals
					if (cur_v_q) begin
						cur_v_q <= 1'b0;
						if (len_q < prqs_pkg::CNT_W'(prqs_pkg::MAX_TASKS)) len_q <= len_q + 1'b1;
					end
					state_q <= S_POP;
				end
				S_POP: begin
					// run the head of the queue
					if (len_q != '0) begin
						cur_q   <= rq_q[0];
						cur_v_q <= 1'b1;
						len_q   <= len_q - 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					done          <= 1'b1;
					status        <= sts_q;
					new_task_id   <= newid_q;
					running_valid <= cur_v_q;
					running_id    <= cur_v_q ? cur_q.id : 32'd0;
					total_count   <= 5'(total_q);
					active_count  <= 5'(len_q + prqs_pkg::CNT_W'(cur_v_q));
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/priority_ready_queue_scheduler_core.sv
// Priority ready-queue task scheduler.
// Input channel: drive func, task_id and priority_req with start high; the
// item is taken at a clock edge where start is high and busy is low. A
// two-item command queue sits in front of the execution sequencer, so busy
// rises only when both queue entries are occupied.
// Result channel: done is high for exactly one cycle with status,
// new_task_id, running_valid, running_id, total_count and active_count.
// The receiver cannot stall; every item produces exactly one result.
// Once taken in S_IDLE, an item passes S_EXEC and S_DONE for create, exit
// with no task running, destroy of a task that is not running, ticks below
// the quantum and unused codes; S_EXEC, S_POP and S_DONE for exit or destroy
// of the running task; S_EXEC, S_ENQ, S_POP and S_DONE for schedule and for
// a tick that reaches the quantum. The sequencer takes the next item once
// the previous one has reported. The quantum in ticks is written via
// quantum_we / quantum_wdata; write it only while idle, the block does not
// enforce this. After reset the init task (id 1, priority 10) runs in
// slot 0, the ready queue is empty, the next id is 2, the quantum 10 ticks.
module priority_ready_queue_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [31:0] task_id,
	input  logic [7:0]  priority_req,
	input  logic        quantum_we,
	input  logic [7:0]  quantum_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] new_task_id,
	output logic        running_valid,
	output logic [31:0] running_id,
	output logic [4:0]  total_count,
	output logic [4:0]  active_count
);

	prqs_pkg::cmd_t cmd_in;
	prqs_pkg::cmd_t cmd_out;
	logic       cmd_valid;
	logic       cmd_pop;
	logic [7:0] quantum_q;

	assign cmd_in = '{func: func, task_id: task_id, priority_req: priority_req};

	// hold the quantum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= prqs_pkg::QUANTUM_RESET;
		end else if (quantum_we) begin
			quantum_q <= quantum_wdata;
		end
	end

	prqs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd_in    (cmd_in),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd_out   (cmd_out),
		.cmd_pop   (cmd_pop)
	);

	prqs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_in        (cmd_out),
		.cmd_pop       (cmd_pop),
		.quantum_q     (quantum_q),
		.done          (done),
		.status        (status),
		.new_task_id   (new_task_id),
		.running_valid (running_valid),
		.running_id    (running_id),
		.total_count   (total_count),
		.active_count  (active_count)
	);

`ifndef NO_ASSERTIONS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");
	a_active_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> active_count <= total_count) else $error("active exceeds total");
	a_norun_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == prqs_pkg::STS_NORUN |-> !running_valid)
		else $error("no-running status with running task");
	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && !running_valid |-> running_id == 32'd0) else $error("idle with id");
`endif

endmodule
